### src/sab_pkg.sv
// sab_pkg: shared types and constants for the suffix automaton builder.
// No dependencies.
package sab_pkg;

  localparam int MAX_TEXT_DEF = 256;
  localparam int ALPHABET_DEF = 256;
  localparam int SYM_W        = 8;
  localparam int OUT_W        = 9;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REFUSE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_CHECK,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_REDIR_RD,
    ST_REDIR_EV,
    ST_FIX,
    ST_FINISH
  } sab_state_t;

endpackage

### src/suffix_automaton_builder_core.sv
// suffix_automaton_builder_core: online suffix automaton construction, one
// byte per request, with a sequencer around one transition memory port.
// Depends on sab_pkg.
//
// An accepted request walks the suffix links from the last state, checks
// the lengths when the walk stops on an existing transition, and for a
// clone copies the row of ALPHABET entries, redirects the transitions that
// pointed at the old state and fixes its link; a refused request goes
// straight to its result. One request at a time; busy stays high until the
// out_valid strobe. The receiver cannot stall; each result shows one cycle.
// Reset: synchronous, active low; afterwards a clearing pass empties the
// whole transition store, with busy high.
module suffix_automaton_builder_core #(
  parameter int MAX_TEXT = sab_pkg::MAX_TEXT_DEF,
  parameter int ALPHABET = sab_pkg::ALPHABET_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [sab_pkg::SYM_W-1:0] in_symbol,
  output logic                      out_valid,
  output logic [sab_pkg::OUT_W-1:0] out_new_state,
  output logic [sab_pkg::OUT_W-1:0] out_link_state,
  output logic                      out_made_clone,
  output logic [sab_pkg::OUT_W-1:0] out_clone_index,
  output logic [sab_pkg::OUT_W-1:0] out_state_count,
  output logic                      out_refused
);

  localparam int NSTATES = 2 * MAX_TEXT;
  localparam int SW      = $clog2(NSTATES + 1);   // holds the no-link marker
  localparam int IW      = $clog2(NSTATES);       // state index
  localparam int AW      = $clog2(ALPHABET);      // symbol index
  localparam int LW      = $clog2(MAX_TEXT + 1);  // lengths
  localparam int TW      = IW + AW;               // transition address
  localparam logic [SW-1:0] NO_LINK = SW'(NSTATES);

  // Storage. Transition entries hold target + 1; zero is empty.
  logic [SW-1:0] trans_mem [2**TW];
  logic [LW-1:0] len_mem   [2**IW];
  logic [SW-1:0] link_mem  [2**IW];

  logic [TW-1:0] t_raddr, t_waddr;
  logic [SW-1:0] t_wdata, t_q;
  logic          t_we;
  logic [IW-1:0] s_raddr, len_waddr, link_waddr;
  logic [LW-1:0] len_wdata, len_q;
  logic [SW-1:0] link_wdata, link_q;
  logic          len_we, link_we;

  always_ff @(posedge clk) begin
    if (t_we) begin
      trans_mem[t_waddr] <= t_wdata;
    end
    t_q <= trans_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q <= len_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[s_raddr];
  end

  sab_pkg::sab_state_t state_r, state_nxt;
  logic [TW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] used_r, used_nxt;
  logic [IW-1:0] last_r, last_nxt;
  logic [LW-1:0] tlen_r, tlen_nxt;
  logic [AW-1:0] sym_r, sym_nxt;
  logic [SW-1:0] p_r, p_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] q_r, q_nxt;
  logic [IW-1:0] clone_r, clone_nxt;
  logic          made_r, made_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [IW-1:0] curlink_r, curlink_nxt;
  logic [AW-1:0] k_r, k_nxt;

  logic                      ov_nxt, oref_nxt, omade_nxt;
  logic [sab_pkg::OUT_W-1:0] onew_nxt, olink_nxt, oclone_nxt, ocount_nxt;

  logic          sym_bad;
  logic [IW-1:0] t_target;

  assign sym_bad  = {1'b0, in_symbol} >= (sab_pkg::SYM_W + 1)'(ALPHABET);
  assign t_target = IW'(t_q - SW'(1));
  assign busy     = (state_r != sab_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sab_pkg::ST_CLEAR;
      clr_r     <= '0;
      used_r    <= SW'(1);
      last_r    <= '0;
      tlen_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      used_r    <= used_nxt;
      last_r    <= last_nxt;
      tlen_r    <= tlen_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r           <= sym_nxt;
    p_r             <= p_nxt;
    cur_r           <= cur_nxt;
    q_r             <= q_nxt;
    clone_r         <= clone_nxt;
    made_r          <= made_nxt;
    plen_r          <= plen_nxt;
    curlink_r       <= curlink_nxt;
    k_r             <= k_nxt;
    out_refused     <= oref_nxt;
    out_made_clone  <= omade_nxt;
    out_new_state   <= onew_nxt;
    out_link_state  <= olink_nxt;
    out_clone_index <= oclone_nxt;
    out_state_count <= ocount_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    used_nxt    = used_r;
    last_nxt    = last_r;
    tlen_nxt    = tlen_r;
    sym_nxt     = sym_r;
    p_nxt       = p_r;
    cur_nxt     = cur_r;
    q_nxt       = q_r;
    clone_nxt   = clone_r;
    made_nxt    = made_r;
    plen_nxt    = plen_r;
    curlink_nxt = curlink_r;
    k_nxt       = k_r;
    ov_nxt      = 1'b0;
    oref_nxt    = out_refused;
    omade_nxt   = out_made_clone;
    onew_nxt    = out_new_state;
    olink_nxt   = out_link_state;
    oclone_nxt  = out_clone_index;
    ocount_nxt  = out_state_count;

    t_raddr    = {p_r[IW-1:0], sym_r};
    t_we       = 1'b0;
    t_waddr    = {p_r[IW-1:0], sym_r};
    t_wdata    = '0;
    s_raddr    = p_r[IW-1:0];
    len_we     = 1'b0;
    len_waddr  = cur_r;
    len_wdata  = '0;
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = '0;

    unique case (state_r)
      sab_pkg::ST_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_r;
        t_wdata = '0;
        // root: length zero, no suffix link
        if (clr_r == '0) begin
          len_we     = 1'b1;
          len_waddr  = '0;
          len_wdata  = '0;
          link_we    = 1'b1;
          link_waddr = '0;
          link_wdata = NO_LINK;
        end
        clr_nxt = clr_r + TW'(1);
        if (clr_r == '1) begin
          state_nxt = sab_pkg::ST_IDLE;
        end
      end

      sab_pkg::ST_IDLE: begin
        s_raddr = last_r;   // link of last, for a refusal
        if (start) begin
          sym_nxt = AW'(in_symbol);
          if (sym_bad || tlen_r >= LW'(MAX_TEXT) || used_r >= SW'(NSTATES)) begin
            state_nxt = sab_pkg::ST_REFUSE;
          end else begin
            cur_nxt     = IW'(used_r);
            used_nxt    = used_r + SW'(1);
            len_we      = 1'b1;
            len_waddr   = IW'(used_r);
            len_wdata   = tlen_r + LW'(1);
            p_nxt       = SW'(last_r);
            curlink_nxt = '0;
            made_nxt    = 1'b0;
            clone_nxt   = '0;
            state_nxt   = sab_pkg::ST_WALK_RD;
          end
        end
      end

      sab_pkg::ST_REFUSE: begin
        ov_nxt     = 1'b1;
        oref_nxt   = 1'b1;
        omade_nxt  = 1'b0;
        onew_nxt   = sab_pkg::OUT_W'(last_r);
        olink_nxt  = (link_q == NO_LINK) ? '0 : sab_pkg::OUT_W'(link_q);
        oclone_nxt = '0;
        ocount_nxt = sab_pkg::OUT_W'(used_r);
        state_nxt  = sab_pkg::ST_IDLE;
      end

      sab_pkg::ST_WALK_RD: begin
        state_nxt = sab_pkg::ST_WALK_EV;
      end

      sab_pkg::ST_WALK_EV: begin
        if (t_q == '0) begin
          // empty: point it at the new state and follow the link
          t_we    = 1'b1;
          t_wdata = SW'(cur_r) + SW'(1);
          p_nxt   = link_q;
          if (link_q == NO_LINK) begin
            state_nxt = sab_pkg::ST_FINISH;
          end else begin
            state_nxt = sab_pkg::ST_WALK_RD;
          end
        end else begin
          q_nxt     = t_target;
          plen_nxt  = len_q;
          s_raddr   = t_target;
          state_nxt = sab_pkg::ST_CHECK;
        end
      end

      sab_pkg::ST_CHECK: begin
        if (plen_r + LW'(1) == len_q) begin
          curlink_nxt = q_r;
          state_nxt   = sab_pkg::ST_FINISH;
        end else begin
          clone_nxt  = IW'(used_r);
          used_nxt   = used_r + SW'(1);
          made_nxt   = 1'b1;
          len_we     = 1'b1;
          len_waddr  = IW'(used_r);
          len_wdata  = plen_r + LW'(1);
          link_we    = 1'b1;
          link_waddr = IW'(used_r);
          link_wdata = link_q;
          k_nxt      = '0;
          state_nxt  = sab_pkg::ST_COPY_RD;
        end
      end

      sab_pkg::ST_COPY_RD: begin
        t_raddr   = {q_r, k_r};
        state_nxt = sab_pkg::ST_COPY_WR;
      end

      sab_pkg::ST_COPY_WR: begin
        t_we    = 1'b1;
        t_waddr = {clone_r, k_r};
        t_wdata = t_q;
        k_nxt   = k_r + AW'(1);
        if (k_r == AW'(ALPHABET - 1)) begin
          state_nxt = sab_pkg::ST_REDIR_RD;
        end else begin
          state_nxt = sab_pkg::ST_COPY_RD;
        end
      end

      sab_pkg::ST_REDIR_RD: begin
        state_nxt = sab_pkg::ST_REDIR_EV;
      end

      sab_pkg::ST_REDIR_EV: begin
        if (t_q == SW'(q_r) + SW'(1)) begin
          t_we    = 1'b1;
          t_wdata = SW'(clone_r) + SW'(1);
          p_nxt   = link_q;
          if (link_q == NO_LINK) begin
            state_nxt = sab_pkg::ST_FIX;
          end else begin
            state_nxt = sab_pkg::ST_REDIR_RD;
          end
        end else begin
          state_nxt = sab_pkg::ST_FIX;
        end
      end

      sab_pkg::ST_FIX: begin
        link_we     = 1'b1;
        link_waddr  = q_r;
        link_wdata  = SW'(clone_r);
        curlink_nxt = clone_r;
        state_nxt   = sab_pkg::ST_FINISH;
      end

      sab_pkg::ST_FINISH: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = SW'(curlink_r);
        last_nxt   = cur_r;
        tlen_nxt   = tlen_r + LW'(1);
        ov_nxt     = 1'b1;
        oref_nxt   = 1'b0;
        omade_nxt  = made_r;
        onew_nxt   = sab_pkg::OUT_W'(cur_r);
        olink_nxt  = sab_pkg::OUT_W'(curlink_r);
        oclone_nxt = sab_pkg::OUT_W'(clone_r);
        ocount_nxt = sab_pkg::OUT_W'(used_r);
        state_nxt  = sab_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = sab_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### test/tb.sv
// tb: self-checking bench for suffix_automaton_builder_core, one symbol per request.
// Depends on sab_pkg and the core; holds its own automaton predictor.
module tb;

  localparam int TEXT_CAP  = sab_pkg::MAX_TEXT_DEF;
  localparam int SIGMA     = sab_pkg::ALPHABET_DEF;
  localparam int NST       = 2 * TEXT_CAP;
  localparam int NONE      = NST;
  localparam int N_RANDOM  = 1280;
  localparam int CYCLE_CAP = 3000000;

  typedef struct packed {
    logic [sab_pkg::OUT_W-1:0] new_state;
    logic [sab_pkg::OUT_W-1:0] link_state;
    logic                      made_clone;
    logic [sab_pkg::OUT_W-1:0] clone_index;
    logic [sab_pkg::OUT_W-1:0] state_count;
    logic                      refused;
  } sa_result_t;

  typedef struct packed {
    logic [sab_pkg::SYM_W-1:0] sym;
    logic                      drain;  // wait for all answers before issuing
  } sym_req_t;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      start = 0;
  logic [sab_pkg::SYM_W-1:0] in_symbol = '0;
  logic                      busy, out_valid, out_made_clone, out_refused;
  logic [sab_pkg::OUT_W-1:0] out_new_state, out_link_state, out_clone_index;
  logic [sab_pkg::OUT_W-1:0] out_state_count;

  suffix_automaton_builder_core dut (
    .clk, .rst_n, .start, .busy, .in_symbol, .out_valid, .out_new_state,
    .out_link_state, .out_made_clone, .out_clone_index, .out_state_count, .out_refused
  );

  // predictor copy of the automaton; rows hold target+1, 0 = empty
  int         sa_row [0:NST*SIGMA-1];
  int         sa_len [0:NST-1];
  int         sa_link[0:NST-1];
  int         sa_used, sa_last;

  sym_req_t   pending_syms[$];
  sa_result_t expected_steps[$];
  int         n_errors = 0;
  int         n_issued = 0;
  int         n_cycles = 0;
  bit         took_req = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_errors++;
  endtask

  task automatic predict_append(input logic [sab_pkg::SYM_W-1:0] sym,
                                output sa_result_t r);
    int cur, p, q, cl, s;
    r = '0;
    s = int'(sym);
    if (s >= SIGMA || sa_len[sa_last] >= TEXT_CAP || sa_used + 2 > NST + 1) begin
      r.new_state   = sab_pkg::OUT_W'(sa_last);
      r.link_state  = (sa_link[sa_last] == NONE) ? '0 : sab_pkg::OUT_W'(sa_link[sa_last]);
      r.state_count = sab_pkg::OUT_W'(sa_used);
      r.refused     = 1'b1;
      return;
    end
    cur = sa_used++;
    sa_len[cur]  = sa_len[sa_last] + 1;
    sa_link[cur] = 0;
    p = sa_last;
    while (p != NONE && sa_row[p*SIGMA+s] == 0) begin
      sa_row[p*SIGMA+s] = cur + 1;
      p = sa_link[p];
    end
    if (p != NONE) begin
      q = (sa_row[p*SIGMA+s] - 1) % NST;
      if (sa_len[p] + 1 == sa_len[q]) begin
        sa_link[cur] = q;
      end else begin
        // lengths disagree: split q with a clone taking its row
        cl = sa_used++;
        for (int a = 0; a < SIGMA; a++) sa_row[cl*SIGMA+a] = sa_row[q*SIGMA+a];
        sa_len[cl]  = sa_len[p] + 1;
        sa_link[cl] = sa_link[q];
        while (p != NONE && sa_row[p*SIGMA+s] == q + 1) begin
          sa_row[p*SIGMA+s] = cl + 1;
          p = sa_link[p];
        end
        sa_link[q]   = cl;
        sa_link[cur] = cl;
        r.made_clone  = 1'b1;
        r.clone_index = sab_pkg::OUT_W'(cl);
      end
    end
    sa_last       = cur;
    r.new_state   = sab_pkg::OUT_W'(cur);
    r.link_state  = sab_pkg::OUT_W'(sa_link[cur]);
    r.state_count = sab_pkg::OUT_W'(sa_used);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (n_issued < 433) ? 18 : (n_issued < 866) ? 73 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_req) begin
      start <= 1'b1;  // request still waiting on busy
    end else if (pending_syms.size() != 0 &&
                 !(pending_syms[0].drain && expected_steps.size() != 0) &&
                 $urandom_range(99) >= idle_pct) begin
      start     <= 1'b1;
      in_symbol <= pending_syms[0].sym;
    end else begin
      start     <= 1'b0;
      in_symbol <= sab_pkg::SYM_W'($urandom);
    end
  end

  // monitor: acceptance and result checking on the rising edge
  always @(posedge clk) begin
    sa_result_t want;
    took_req <= 1'b0;
    n_cycles <= n_cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected result new_state", int'(out_new_state), -1);
      end else begin
        want = expected_steps.pop_front();
        if (out_new_state !== want.new_state)
          report_mismatch("new_state", int'(out_new_state), int'(want.new_state));
        if (out_link_state !== want.link_state)
          report_mismatch("link_state", int'(out_link_state), int'(want.link_state));
        if (out_made_clone !== want.made_clone)
          report_mismatch("made_clone", int'(out_made_clone), int'(want.made_clone));
        if (out_clone_index !== want.clone_index)
          report_mismatch("clone_index", int'(out_clone_index), int'(want.clone_index));
        if (out_state_count !== want.state_count)
          report_mismatch("state_count", int'(out_state_count), int'(want.state_count));
        if (out_refused !== want.refused)
          report_mismatch("refused", int'(out_refused), int'(want.refused));
      end
    end
    if (rst_n && start && !busy) begin
      predict_append(in_symbol, want);
      expected_steps.push_back(want);
      void'(pending_syms.pop_front());
      n_issued++;
      took_req <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (n_cycles >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sym_req_t      rq;
    logic [7:0]    directed[$];
    for (int i = 0; i < NST*SIGMA; i++) sa_row[i] = 0;
    for (int i = 0; i < NST; i++) begin
      sa_len[i]  = 0;
      sa_link[i] = 0;
    end
    sa_link[0] = NONE;
    sa_used    = 1;
    sa_last    = 0;

    // extremes, repeats and patterns that force clones
    directed = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h61, 8'h61, 8'h62, 8'h61,
                 8'h62, 8'h62, 8'h61, 8'h61, 8'h61, 8'h62, 8'h80, 8'h7F, 8'h55,
                 8'hAA, 8'h61, 8'h62, 8'h63};
    foreach (directed[i]) begin
      rq.sym   = directed[i];
      rq.drain = 1'b0;
      pending_syms.push_back(rq);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // mostly a small alphabet, which keeps the walk and clone paths busy
      if ($urandom_range(99) < 85) rq.sym = sab_pkg::SYM_W'(8'h61 + $urandom_range(2));
      else                         rq.sym = sab_pkg::SYM_W'($urandom);
      rq.drain = (i == 150 || i == 700);
      pending_syms.push_back(rq);
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (pending_syms.size() == 0);
    wait (expected_steps.size() == 0);
    repeat (50) @(posedge clk);
    if (n_errors == 0 && expected_steps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
